/* hw/rtl/bfzc_pkg.sv */
// Package for the zero-cross burst-fire modulator: widths, mode constants
// and the burst pattern table. No dependencies.
package bfzc_pkg;

  localparam int unsigned POWER_W    = 8;
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned REM_W      = 4;
  localparam int unsigned TOTAL_W    = 9;
  localparam int unsigned QUOT_W     = 5;

  localparam int unsigned MODE_STEP  = 15;
  localparam int unsigned MODE_MAX   = 8;
  localparam int unsigned SLOT_COUNT = 9;

  // Reciprocal of the mode step, scaled by 2**RECIP_SHIFT; exact for totals below 290
  localparam int unsigned RECIP_SHIFT = 14;
  localparam int unsigned RECIP_MULT  = 1093;
  localparam int unsigned RECIP_W     = 11;

  // One row per mode, bit n is the drive level for slot n
  localparam logic [SLOT_COUNT-1:0] BURST_ROWS [MODE_MAX+1] = '{
    9'b000000000,
    9'b000010000,
    9'b001000100,
    9'b001010010,
    9'b010101010,
    9'b110110101,
    9'b111011101,
    9'b111110111,
    9'b111111111
  };

  // Look up the drive level; out-of-range mode or slot reads as off
  function automatic logic burst_level(input logic [MODE_W-1:0] mode,
                                       input logic [SLOT_W-1:0] slot);
    logic [SLOT_COUNT-1:0] row;
    logic                  lvl;
    row = '0;
    lvl = 1'b0;
    if ((32'(mode) <= MODE_MAX) && (32'(slot) < SLOT_COUNT)) begin
      row = BURST_ROWS[mode];
      lvl = row[slot];
    end
    return lvl;
  endfunction

endpackage

/* hw/rtl/burst_fire_zero_cross_modulator.sv */
// Top level of the zero-cross burst-fire power modulator.
// Depends on bfzc_pkg for widths, the mode step and the burst pattern table.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction per 1 ms tick with
//   line_crossed, fault_present, relay_allows_heat and power_level.
//   Output channel (out_valid / out_stall): one transaction per tick with
//   opto_on, mode_now and round_done.
//   Config channel (cfg_valid / cfg_ready): writes forced_power from cfg_data;
//   cfg_ready is always high. Write only while the block is idle.
//   The result is registered and appears in the cycle after the input is accepted.
//   Throughput: one tick per cycle while the receiver does not stall; all state update is one pass of logic
//   (a constant-reciprocal divide by 15 and a table lookup) into the state
//   and result registers.
//   When the receiver stalls, the result register holds and in_stall rises,
//   so no further tick is taken until the result is delivered.
//   Reset: the modulator state is cleared (output off, mode 0, first round
//   runs all off), forced_power is zero and the output channel is empty.
module burst_fire_zero_cross_modulator
  import bfzc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input ticks
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               line_crossed,
  input  logic               fault_present,
  input  logic               relay_allows_heat,
  input  logic [POWER_W-1:0] power_level,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic               opto_on,
  output logic [MODE_W-1:0]  mode_now,
  output logic               round_done,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [POWER_W-1:0] cfg_data
);

  logic [POWER_W-1:0] forced_power;
  logic [SLOT_W-1:0]  slot_index, slot_index_next;
  logic               offset_phase, offset_phase_next;
  logic               refresh_pending, refresh_pending_next;
  logic [MODE_W-1:0]  pattern_mode, pattern_mode_next;
  logic [REM_W-1:0]   carry_remainder, carry_remainder_next;
  logic               output_level, output_level_next;
  logic               done_next;

  logic                       in_accept;
  logic                       heat_ok;
  logic [POWER_W-1:0]         power_sel;
  logic [TOTAL_W-1:0]         total;
  logic [TOTAL_W+RECIP_W-1:0] quot_prod;
  logic [QUOT_W-1:0]          quot;
  logic [TOTAL_W-1:0]         quot_times_step;
  logic [TOTAL_W-1:0]         rem_full;
  logic [MODE_W-1:0]          use_mode;
  logic [SLOT_W-1:0]          slot_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Pick the power source and split it into mode and carried remainder
  assign heat_ok         = ~fault_present & ((forced_power != '0) | relay_allows_heat);
  assign power_sel       = (forced_power != '0) ? forced_power : power_level;
  assign total           = TOTAL_W'(power_sel) + TOTAL_W'(carry_remainder);
  assign quot_prod       = TOTAL_W'(total) * RECIP_W'(RECIP_MULT);
  assign quot            = quot_prod[RECIP_SHIFT +: QUOT_W];
  assign quot_times_step = TOTAL_W'(quot) * TOTAL_W'(MODE_STEP);
  assign rem_full        = total - quot_times_step;
  assign slot_inc        = slot_index + SLOT_W'(1);

  // Next state for one tick
  always_comb begin
    slot_index_next      = slot_index;
    offset_phase_next    = offset_phase;
    refresh_pending_next = refresh_pending;
    pattern_mode_next    = pattern_mode;
    carry_remainder_next = carry_remainder;
    output_level_next    = output_level;
    done_next            = 1'b0;
    use_mode             = pattern_mode;
    if (line_crossed) begin
      if (heat_ok) begin
        // refresh the mode at the first crossing of a new round
        if (refresh_pending) begin
          carry_remainder_next = rem_full[REM_W-1:0];
          if (32'(quot) > MODE_MAX) begin
            use_mode = MODE_W'(MODE_MAX);
          end else begin
            use_mode = quot[MODE_W-1:0];
          end
          pattern_mode_next    = use_mode;
          refresh_pending_next = 1'b0;
        end
        output_level_next = burst_level(use_mode, slot_index);
        // advance the slot and close the round at its end
        slot_index_next = slot_inc;
        if (offset_phase) begin
          if (32'(slot_inc) == SLOT_COUNT) begin
            slot_index_next      = '0;
            offset_phase_next    = 1'b0;
            refresh_pending_next = 1'b1;
            done_next            = 1'b1;
          end
        end else if (32'(slot_inc) == SLOT_COUNT - 1) begin
          slot_index_next      = SLOT_W'(1);
          offset_phase_next    = 1'b1;
          refresh_pending_next = 1'b1;
          done_next            = 1'b1;
        end
      end else begin
        // drop everything when heating is not permitted
        slot_index_next      = '0;
        offset_phase_next    = 1'b0;
        refresh_pending_next = 1'b0;
        pattern_mode_next    = '0;
        carry_remainder_next = '0;
        output_level_next    = 1'b0;
      end
    end
  end

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      forced_power <= '0;
    end else if (cfg_valid && cfg_ready) begin
      forced_power <= cfg_data;
    end
  end

  // Update modulator state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index      <= '0;
      offset_phase    <= 1'b0;
      refresh_pending <= 1'b0;
      pattern_mode    <= '0;
      carry_remainder <= '0;
      output_level    <= 1'b0;
    end else if (in_accept) begin
      slot_index      <= slot_index_next;
      offset_phase    <= offset_phase_next;
      refresh_pending <= refresh_pending_next;
      pattern_mode    <= pattern_mode_next;
      carry_remainder <= carry_remainder_next;
      output_level    <= output_level_next;
    end
  end

  // Track the output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      opto_on    <= output_level_next;
      mode_now   <= pattern_mode_next;
      round_done <= done_next;
    end
  end

endmodule

/* test/burst_fire_zero_cross_modulator_tb.sv */
// Self-checking testbench for burst_fire_zero_cross_modulator: a directed tick table,
// then random tick phases under several forced power settings, all checked per result.
// Depends on bfzc_pkg and the modulator RTL only.
`timescale 1ns / 1ps

module burst_fire_zero_cross_modulator_tb
  import bfzc_pkg::*;
();

  localparam int STEP_UNITS  = 15;
  localparam int TOP_MODE    = 8;
  localparam int SLOTS       = 9;
  localparam int PHASE_TICKS = 210;

  typedef enum logic [0:0] {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic               crossed;
    logic               fault;
    logic               relay;
    logic [POWER_W-1:0] power;
  } tick_t;

  typedef struct packed {
    logic              opto;
    logic [MODE_W-1:0] mode;
    logic              done;
  } drive_t;

  // Result fixed by the table for one tick, used in place of the prediction
  typedef struct packed {
    logic   typed;
    drive_t want;
  } fixed_answer_t;

  // For a register row, value is the forced power to write
  typedef struct packed {
    row_kind_e          kind;
    logic               crossed;
    logic               fault;
    logic               relay;
    logic [POWER_W-1:0] value;
    logic               typed;
    logic               opto;
    logic [MODE_W-1:0]  mode;
    logic               done;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               line_crossed = 1'b0;
  logic               fault_present = 1'b0;
  logic               relay_allows_heat = 1'b0;
  logic [POWER_W-1:0] power_level = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               opto_on;
  logic [MODE_W-1:0]  mode_now;
  logic               round_done;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [POWER_W-1:0] cfg_data = '0;

  // Burst pattern per mode, indexed by slot
  bit pattern_tbl [SLOTS][SLOTS] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{0, 0, 1, 0, 0, 0, 1, 0, 0},
    '{0, 1, 0, 0, 1, 0, 1, 0, 0},
    '{0, 1, 0, 1, 0, 1, 0, 1, 0},
    '{1, 0, 1, 0, 1, 1, 0, 1, 1},
    '{1, 0, 1, 1, 1, 0, 1, 1, 1},
    '{1, 1, 1, 0, 1, 1, 1, 1, 1},
    '{1, 1, 1, 1, 1, 1, 1, 1, 1}
  };

  // kind, crossed, fault, relay, value, typed, opto, mode, done
  dir_row_t dir_rows [22] = '{
    '{ROW_TICK, 0, 0, 1, 255, 1, 0, 0, 0},  // no crossing after reset: all held at zero
    '{ROW_TICK, 1, 1, 1, 255, 1, 0, 0, 0},  // fault on a crossing
    '{ROW_TICK, 1, 0, 0, 255, 1, 0, 0, 0},  // relay blocks heat, nothing forced
    '{ROW_TICK, 1, 0, 1, 255, 1, 0, 0, 0},  // first round after reset runs all off
    '{ROW_TICK, 1, 0, 1, 255, 1, 0, 0, 0},
    '{ROW_TICK, 1, 0, 1, 255, 1, 0, 0, 0},
    '{ROW_TICK, 1, 0, 1, 255, 1, 0, 0, 0},
    '{ROW_TICK, 1, 0, 1, 255, 1, 0, 0, 0},
    '{ROW_TICK, 1, 0, 1, 255, 1, 0, 0, 0},
    '{ROW_TICK, 1, 0, 1, 255, 1, 0, 0, 0},
    '{ROW_TICK, 1, 0, 1, 255, 1, 0, 0, 1},  // eighth crossing closes the round
    '{ROW_TICK, 1, 0, 1, 255, 1, 1, 8, 0},  // full power clamps to the top mode
    '{ROW_TICK, 0, 0, 0,   0, 1, 1, 8, 0},  // no crossing holds output even with relay off
    '{ROW_TICK, 1, 0, 1,   0, 0, 0, 0, 0},
    '{ROW_TICK, 1, 1, 0,   0, 1, 0, 0, 0},  // fault clears everything
    '{ROW_CFG,  0, 0, 0, 255, 0, 0, 0, 0},
    '{ROW_TICK, 1, 0, 0,   0, 0, 0, 0, 0},  // forced power heats with relay off
    '{ROW_TICK, 1, 0, 0,   0, 0, 0, 0, 0},
    '{ROW_TICK, 1, 1, 1,   0, 1, 0, 0, 0},  // fault wins over forced power
    '{ROW_CFG,  0, 0, 0,   0, 0, 0, 0, 0},
    '{ROW_TICK, 1, 0, 0, 170, 1, 0, 0, 0},
    '{ROW_TICK, 0, 1, 0,  85, 1, 0, 0, 0}
  };

  // Modulator state mirrored by the predictor
  logic [POWER_W-1:0] forced_q  = '0;
  logic [3:0]         slot_q    = '0;
  logic               phase_q   = 1'b0;
  logic               refresh_q = 1'b0;
  logic [MODE_W-1:0]  mode_q    = '0;
  logic [3:0]         carry_q   = '0;
  logic               level_q   = 1'b0;

  drive_t        pending_drives [$];
  fixed_answer_t fixed_answers [$];
  int            ticks_taken = 0;
  int            drives_seen = 0;
  int            mismatches  = 0;
  bit            idle_on     = 1'b1;

  burst_fire_zero_cross_modulator u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .line_crossed      (line_crossed),
    .fault_present     (fault_present),
    .relay_allows_heat (relay_allows_heat),
    .power_level       (power_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .opto_on           (opto_on),
    .mode_now          (mode_now),
    .round_done        (round_done),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  // Advance the modulator by one tick and return the drive it reports
  function automatic drive_t advance_modulator(tick_t t);
    drive_t     d;
    logic [8:0] total;
    logic [4:0] quot;
    d.done = 1'b0;
    if (t.crossed) begin
      if (!t.fault && (forced_q != 0 || t.relay)) begin
        if (refresh_q) begin
          total = 9'(forced_q != 0 ? forced_q : t.power) + 9'(carry_q);
          quot = 5'(total / STEP_UNITS);
          carry_q = 4'(total - quot * STEP_UNITS);
          mode_q = (quot > TOP_MODE) ? MODE_W'(TOP_MODE) : quot[MODE_W-1:0];
          refresh_q = 1'b0;
        end
        level_q = (mode_q <= TOP_MODE && slot_q < SLOTS) ? pattern_tbl[mode_q][slot_q] : 1'b0;
        slot_q = slot_q + 4'd1;
        // rounds alternate: with phase_q clear slots 0..7 run, with it set slots 1..8
        if (phase_q) begin
          if (slot_q == SLOTS) begin
            slot_q = '0;
            phase_q = 1'b0;
            refresh_q = 1'b1;
            d.done = 1'b1;
          end
        end else if (slot_q == SLOTS - 1) begin
          slot_q = 4'd1;
          phase_q = 1'b1;
          refresh_q = 1'b1;
          d.done = 1'b1;
        end
      end else begin
        slot_q = '0;
        phase_q = 1'b0;
        refresh_q = 1'b0;
        mode_q = '0;
        carry_q = '0;
        level_q = 1'b0;
      end
    end
    d.opto = level_q;
    d.mode = mode_q;
    return d;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 40)
      $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Present one tick, after a random gap while idling is on, and hold it until taken
  task automatic send_tick(tick_t t, fixed_answer_t ans);
    while (idle_on && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    fixed_answers.push_back(ans);
    in_valid          <= 1'b1;
    line_crossed      <= t.crossed;
    fault_present     <= t.fault;
    relay_allows_heat <= t.relay;
    power_level       <= t.power;
    do @(posedge clk); while (in_stall);
    ticks_taken++;
  endtask

  // Drop valid and wait until every transaction has come back
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (drives_seen < ticks_taken) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_forced(logic [POWER_W-1:0] v);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stalls at random while idling is on
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 28);
  end

  // Watch the channels: predict on each accepted tick, check each result
  always @(posedge clk) begin
    tick_t         seen;
    drive_t        want;
    drive_t        guess;
    fixed_answer_t ans;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        drives_seen++;
        if (pending_drives.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", drives_seen));
        end else begin
          want = pending_drives.pop_front();
          if (opto_on !== want.opto)
            report_mismatch($sformatf("result %0d opto_on %b, want %b",
                                      drives_seen, opto_on, want.opto));
          if (mode_now !== want.mode)
            report_mismatch($sformatf("result %0d mode_now %0d, want %0d",
                                      drives_seen, mode_now, want.mode));
          if (round_done !== want.done)
            report_mismatch($sformatf("result %0d round_done %b, want %b",
                                      drives_seen, round_done, want.done));
        end
      end
      if (cfg_valid && cfg_ready)
        forced_q = cfg_data;
      if (in_valid && !in_stall) begin
        seen = '{line_crossed, fault_present, relay_allows_heat, power_level};
        guess = advance_modulator(seen);
        ans = (fixed_answers.size() != 0) ? fixed_answers.pop_front() : '0;
        pending_drives.push_back(ans.typed ? ans.want : guess);
      end
    end
  end

  // Stimulus
  initial begin
    tick_t              t;
    fixed_answer_t      ans;
    logic [POWER_W-1:0] forced_plan [8];
    int                 sel;
    forced_plan = '{8'd0, 8'd255, 8'd1, 8'd15, 8'd0, 8'd14, 8'd0, 8'd128};
    forced_plan[6] = POWER_W'($urandom_range(2, 254));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_forced(dir_rows[i].value);
      end else begin
        t = '{dir_rows[i].crossed, dir_rows[i].fault, dir_rows[i].relay, dir_rows[i].value};
        ans.typed = dir_rows[i].typed;
        ans.want = '{dir_rows[i].opto, dir_rows[i].mode, dir_rows[i].done};
        send_tick(t, ans);
      end
    end

    // Random phases, one forced power setting each; phase 4 runs without idling
    for (int p = 0; p < 8; p++) begin
      write_forced(forced_plan[p]);
      idle_on = (p != 4);
      for (int i = 0; i < PHASE_TICKS; i++) begin
        sel = $urandom_range(99);
        t.crossed = (sel >= 10);
        if (sel < 10) begin
          t.fault = 1'($urandom_range(1));
          t.relay = 1'($urandom_range(1));
        end else begin
          t.fault = (sel == 10);
          t.relay = (sel == 11) ? 1'b0
                  : (forced_plan[p] != 0) ? 1'($urandom_range(1)) : 1'b1;
        end
        case ($urandom_range(9))
          0:       t.power = '0;
          1:       t.power = '1;
          2, 3:    t.power = POWER_W'(STEP_UNITS * $urandom_range(1, 16) - $urandom_range(0, 1));
          default: t.power = POWER_W'($urandom_range(255));
        endcase
        ans = '0;
        send_tick(t, ans);
        // hold off once, mid-way through phase 2, until the pipe is empty
        if (p == 2 && i == PHASE_TICKS / 2)
          settle_idle();
      end
    end

    settle_idle();
    if (pending_drives.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_drives.size()));
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
